/* hdl/izs_pkg.sv */
// Package for the instrument zone selector: payload structs, table entry
// formats, opcodes, state and tier enums, command/status structs.
// No dependencies.
`default_nettype none
package izs_pkg;

   localparam int MAX_PRESETS_DEF = 256;
   localparam int MAX_LAYERS_DEF  = 512;
   localparam int MAX_RANGES_DEF  = 1024;
   localparam int MAX_MATCHES_DEF = 64;

   typedef enum logic [1:0] {
      OP_LOAD_PRESET = 2'd0,
      OP_LOAD_LAYER  = 2'd1,
      OP_LOAD_RANGE  = 2'd2,
      OP_LOOKUP      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_PRESET_COUNT = 2'd0,
      CSR_LAYER_COUNT  = 2'd1,
      CSR_RANGE_COUNT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      TIER_EXACT = 2'd0,
      TIER_PROG  = 2'd1,
      TIER_DRUM  = 2'd2
   } tier_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P_RD,
      ST_P_CHK,
      ST_L_RD,
      ST_L_CHK,
      ST_R_RD,
      ST_R_CHK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [1:0] op;
      logic [9:0] entry_index;
      logic [7:0] owner_index;
      logic [7:0] instrument_index;
      logic       is_drum;
      logic [6:0] bank_msb;
      logic [6:0] bank_lsb;
      logic [6:0] program_req;
      logic [6:0] key_low;
      logic [6:0] key_high;
      logic [6:0] vel_low;
      logic [6:0] vel_high;
   } req_type;

   typedef struct packed {
      logic       preset_found;
      logic [7:0] preset_index;
      logic       zone_valid;
      logic [9:0] range_index;
      logic       overflow;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       drum;
      logic [6:0] msb;
      logic [6:0] lsb;
      logic [6:0] prog;
   } preset_ent_type;

   typedef struct packed {
      logic [7:0] owner;
      logic [6:0] klo;
      logic [6:0] khi;
      logic [6:0] vlo;
      logic [6:0] vhi;
      logic [7:0] inst;
   } layer_ent_type;

   typedef struct packed {
      logic [7:0] owner;
      logic [6:0] klo;
      logic [6:0] khi;
      logic [6:0] vlo;
      logic [6:0] vhi;
   } range_ent_type;

   typedef struct packed {
      logic load_wr;
      logic start_lookup;
      logic p_clear;
      logic tier_inc;
      logic p_inc;
      logic p_take;
      logic l_inc;
      logic l_take;
      logic r_inc;
      logic match;
      logic emit_final;
   } cmd_type;

   typedef struct packed {
      logic p_end;
      logic p_hit;
      logic tier_last;
      logic l_end;
      logic l_hit;
      logic r_end;
      logic r_hit;
   } status_type;

   function automatic logic in_window(input logic [6:0] klo, input logic [6:0] khi,
                                      input logic [6:0] k, input logic [6:0] vlo,
                                      input logic [6:0] vhi, input logic [6:0] v);
      return (klo <= k) && (k <= khi) && (vlo <= v) && (v <= vhi);
   endfunction

endpackage
`default_nettype wire

/* hdl/izs_ctrl.sv */
// Sequencer for the zone selector: preset tiers, layer walk, range walk.
// Depends on izs_pkg.
`default_nettype none
module izs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_op,
   input  wire izs_pkg::status_type status,
   output izs_pkg::cmd_type        cmd,
   output logic                    busy
);
   import izs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_LOOKUP) begin
                  cmd.start_lookup = 1'b1;
                  state_in         = ST_P_RD;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         ST_P_RD: begin
            if (status.p_end) begin
               if (status.tier_last) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.tier_inc = 1'b1;
                  cmd.p_clear  = 1'b1;
               end
            end else begin
               state_in = ST_P_CHK;
            end
         end
         ST_P_CHK: begin
            if (status.p_hit) begin
               cmd.p_take = 1'b1;
               state_in   = ST_L_RD;
            end else begin
               cmd.p_inc = 1'b1;
               state_in  = ST_P_RD;
            end
         end
         ST_L_RD: begin
            state_in = status.l_end ? ST_FIN : ST_L_CHK;
         end
         ST_L_CHK: begin
            if (status.l_hit) begin
               cmd.l_take = 1'b1;
               state_in   = ST_R_RD;
            end else begin
               cmd.l_inc = 1'b1;
               state_in  = ST_L_RD;
            end
         end
         ST_R_RD: begin
            if (status.r_end) begin
               cmd.l_inc = 1'b1;
               state_in  = ST_L_RD;
            end else begin
               state_in = ST_R_CHK;
            end
         end
         ST_R_CHK: begin
            cmd.match = status.r_hit;
            cmd.r_inc = 1'b1;
            state_in  = ST_R_RD;
         end
         ST_FIN: begin
            cmd.emit_final = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/izs_datapath.sv */
// Tables, scan counters, compare logic and result register of the zone selector.
// Depends on izs_pkg.
`default_nettype none
module izs_datapath #(
   parameter int MAX_PRESETS = izs_pkg::MAX_PRESETS_DEF,
   parameter int MAX_LAYERS  = izs_pkg::MAX_LAYERS_DEF,
   parameter int MAX_RANGES  = izs_pkg::MAX_RANGES_DEF,
   parameter int MAX_MATCHES = izs_pkg::MAX_MATCHES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire izs_pkg::req_type    req_data,
   input  wire izs_pkg::cmd_type    cmd,
   input  wire logic                csr_wr,
   input  wire logic [1:0]          csr_index,
   input  wire logic [10:0]         csr_wdata,
   output izs_pkg::status_type      status,
   output logic                     rsp_valid,
   output izs_pkg::rsp_type         rsp_data
);
   import izs_pkg::*;

   localparam int PCW = $clog2(MAX_PRESETS + 1);
   localparam int LCW = $clog2(MAX_LAYERS + 1);
   localparam int RCW = $clog2(MAX_RANGES + 1);
   localparam int MCW = $clog2(MAX_MATCHES + 1);
   localparam int PAW = (MAX_PRESETS > 1) ? $clog2(MAX_PRESETS) : 1;
   localparam int LAW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int RAW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   preset_ent_type preset_mem [MAX_PRESETS];
   layer_ent_type  layer_mem  [MAX_LAYERS];
   range_ent_type  range_mem  [MAX_RANGES];
   preset_ent_type preset_rd_ff;
   layer_ent_type  layer_rd_ff;
   range_ent_type  range_rd_ff;

   logic [8:0]  preset_count_ff;
   logic [9:0]  layer_count_ff;
   logic [10:0] range_count_ff;

   logic [PCW-1:0] pi_ff, pi_in, p_ff, p_in;
   logic [LCW-1:0] li_ff, li_in;
   logic [RCW-1:0] ri_ff, ri_in;
   logic [MCW-1:0] n_ff, n_in;
   logic [1:0]     tier_ff, tier_in;
   logic           found_ff, found_in;
   logic           ovf_ff, ovf_in;
   logic           pend_ff, pend_in;
   logic [RCW-1:0] pend_idx_ff, pend_idx_in;
   logic [7:0]     inst_ff, inst_in;
   logic           drum_ff;
   logic [6:0]     msb_ff, lsb_ff, prog_ff, key_ff, vel_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start_lookup) begin
         drum_ff <= req_data.is_drum;
         msb_ff  <= req_data.bank_msb;
         lsb_ff  <= req_data.bank_lsb;
         prog_ff <= req_data.program_req;
         key_ff  <= req_data.key_low;
         vel_ff  <= req_data.vel_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_count_ff <= '0;
         layer_count_ff  <= '0;
         range_count_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_index == CSR_PRESET_COUNT) preset_count_ff <= csr_wdata[8:0];
         if (csr_index == CSR_LAYER_COUNT)  layer_count_ff  <= csr_wdata[9:0];
         if (csr_index == CSR_RANGE_COUNT)  range_count_ff  <= csr_wdata;
      end
   end

   // table memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.load_wr && req_data.op == OP_LOAD_PRESET &&
          32'(req_data.entry_index) < MAX_PRESETS) begin
         preset_mem[PAW'(req_data.entry_index)] <= '{req_data.is_drum, req_data.bank_msb,
                                                    req_data.bank_lsb, req_data.program_req};
      end
      preset_rd_ff <= preset_mem[pi_ff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && req_data.op == OP_LOAD_LAYER &&
          32'(req_data.entry_index) < MAX_LAYERS) begin
         layer_mem[LAW'(req_data.entry_index)] <= '{req_data.owner_index, req_data.key_low,
                                                   req_data.key_high, req_data.vel_low,
                                                   req_data.vel_high,
                                                   req_data.instrument_index};
      end
      layer_rd_ff <= layer_mem[li_ff[LAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && req_data.op == OP_LOAD_RANGE &&
          32'(req_data.entry_index) < MAX_RANGES) begin
         range_mem[RAW'(req_data.entry_index)] <= '{req_data.owner_index, req_data.key_low,
                                                   req_data.key_high, req_data.vel_low,
                                                   req_data.vel_high};
      end
      range_rd_ff <= range_mem[ri_ff[RAW-1:0]];
   end

   // status
   always_comb begin
      status.p_end = (32'(pi_ff) >= 32'(preset_count_ff)) || (32'(pi_ff) >= MAX_PRESETS);
      status.l_end = (32'(li_ff) >= 32'(layer_count_ff)) || (32'(li_ff) >= MAX_LAYERS);
      status.r_end = (32'(ri_ff) >= 32'(range_count_ff)) || (32'(ri_ff) >= MAX_RANGES);
      status.tier_last = (tier_ff == TIER_DRUM);
      status.p_hit = (preset_rd_ff.drum == drum_ff) &&
                     ((tier_ff == TIER_DRUM) ||
                      ((preset_rd_ff.prog == prog_ff) &&
                       ((tier_ff == TIER_PROG) ||
                        ((preset_rd_ff.msb == msb_ff) && (preset_rd_ff.lsb == lsb_ff)))));
      status.l_hit = (32'(layer_rd_ff.owner) == 32'(p_ff)) &&
                     in_window(layer_rd_ff.klo, layer_rd_ff.khi, key_ff,
                               layer_rd_ff.vlo, layer_rd_ff.vhi, vel_ff);
      status.r_hit = (range_rd_ff.owner == inst_ff) &&
                     in_window(range_rd_ff.klo, range_rd_ff.khi, key_ff,
                               range_rd_ff.vlo, range_rd_ff.vhi, vel_ff);
   end

   always_comb begin
      pi_in        = pi_ff;
      p_in         = p_ff;
      li_in        = li_ff;
      ri_in        = ri_ff;
      n_in         = n_ff;
      tier_in      = tier_ff;
      found_in     = found_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      inst_in      = inst_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.start_lookup) begin
         pi_in    = '0;
         tier_in  = TIER_EXACT;
         found_in = 1'b0;
         ovf_in   = 1'b0;
         pend_in  = 1'b0;
         n_in     = '0;
         p_in     = '0;
      end
      if (cmd.p_clear) pi_in = '0;
      if (cmd.tier_inc) tier_in = tier_ff + 2'd1;
      if (cmd.p_inc) pi_in = pi_ff + 1'b1;
      if (cmd.p_take) begin
         p_in     = pi_ff;
         found_in = 1'b1;
         li_in    = '0;
      end
      if (cmd.l_inc) li_in = li_ff + 1'b1;
      if (cmd.l_take) begin
         inst_in = layer_rd_ff.inst;
         ri_in   = '0;
      end
      if (cmd.r_inc) ri_in = ri_ff + 1'b1;
      // one match is held back so the final one can carry last
      if (cmd.match) begin
         if (32'(n_ff) < MAX_MATCHES) begin
            rsp_valid_in = pend_ff;
            rsp_in       = '{1'b1, 8'(p_ff), 1'b1, 10'(pend_idx_ff), 1'b0, 1'b0};
            pend_in      = 1'b1;
            pend_idx_in  = ri_ff;
            n_in         = n_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.emit_final) begin
         rsp_valid_in = 1'b1;
         if (pend_ff) begin
            rsp_in = '{1'b1, 8'(p_ff), 1'b1, 10'(pend_idx_ff), ovf_ff, 1'b1};
         end else begin
            rsp_in = '{found_ff, found_ff ? 8'(p_ff) : 8'd0, 1'b0, 10'd0, 1'b0, 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pi_ff        <= '0;
         li_ff        <= '0;
         ri_ff        <= '0;
         n_ff         <= '0;
         tier_ff      <= TIER_EXACT;
         found_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pi_ff        <= pi_in;
         li_ff        <= li_in;
         ri_ff        <= ri_in;
         n_ff         <= n_in;
         tier_ff      <= tier_in;
         found_ff     <= found_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      pend_idx_ff <= pend_idx_in;
      inst_ff     <= inst_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_match_cap: assert property (@(posedge clock) disable iff (reset)
      32'(n_ff) <= MAX_MATCHES) else $error("match count past cap");
   a_notfound_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.preset_found |-> rsp_ff.last && !rsp_ff.zone_valid)
      else $error("not-found result not final");
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow |-> rsp_ff.last) else $error("overflow before last");
   a_nozone_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.zone_valid |-> rsp_ff.last) else $error("empty zone not last");

endmodule
`default_nettype wire

/* hdl/instrument_zone_selector.sv */
// Loads are taken while idle without raising busy; they give no result. A lookup scans
// presets tier by tier (up to 3 tiers), then the layers of the found preset, then the
// ranges of each matching layer, reading then checking each entry; a final state ends it.
// Each match waits for the next result; the receiver cannot stall. busy is high
// from the cycle after a lookup is taken until the final result is registered.
// Synchronous reset clears control and counts; tables hold garbage until loaded.
// Top level; depends on izs_pkg, izs_ctrl, izs_datapath.
`default_nettype none
module instrument_zone_selector #(
   parameter int MAX_PRESETS = izs_pkg::MAX_PRESETS_DEF,
   parameter int MAX_LAYERS  = izs_pkg::MAX_LAYERS_DEF,
   parameter int MAX_RANGES  = izs_pkg::MAX_RANGES_DEF,
   parameter int MAX_MATCHES = izs_pkg::MAX_MATCHES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire izs_pkg::req_type req_data,
   output logic                  rsp_valid,
   output izs_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [10:0]      csr_wdata
);
   import izs_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   izs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   izs_datapath #(
      .MAX_PRESETS (MAX_PRESETS),
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_RANGES  (MAX_RANGES),
      .MAX_MATCHES (MAX_MATCHES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_wr    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* sim/tb_instrument_zone_selector.sv */
// Self-checking testbench for instrument_zone_selector: loads the preset, layer
// and range tables, runs note lookups and checks every result transaction.
// Depends on izs_pkg and the instrument_zone_selector RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_instrument_zone_selector;
   import izs_pkg::*;

   class zone_scoreboard;
      preset_ent_type presets [MAX_PRESETS_DEF];
      layer_ent_type  layers  [MAX_LAYERS_DEF];
      range_ent_type  ranges  [MAX_RANGES_DEF];
      int unsigned    preset_cnt, layer_cnt, range_cnt;
      rsp_type        zone_results [$];
      int             errors;

      function void set_count(csr_index_type idx, logic [10:0] val);
         case (idx)
            CSR_PRESET_COUNT: preset_cnt = 32'(val[8:0]);
            CSR_LAYER_COUNT:  layer_cnt  = 32'(val[9:0]);
            CSR_RANGE_COUNT:  range_cnt  = 32'(val);
            default: ;
         endcase
      endfunction

      function void push_zone(logic found, logic [7:0] pidx, logic zv, logic [9:0] ridx,
                              logic ovf, logic lst);
         rsp_type r;
         r.preset_found = found;
         r.preset_index = pidx;
         r.zone_valid   = zv;
         r.range_index  = ridx;
         r.overflow     = ovf;
         r.last         = lst;
         zone_results = {zone_results, r};
      endfunction

      // Applies a load, or predicts the results of a lookup.
      function void note_request(req_type q);
         int unsigned np, nl, nr, p, n;
         bit found, ovf;
         tier_type tier;
         rsp_type r;
         np = (preset_cnt > MAX_PRESETS_DEF) ? MAX_PRESETS_DEF : preset_cnt;
         nl = (layer_cnt > MAX_LAYERS_DEF) ? MAX_LAYERS_DEF : layer_cnt;
         nr = (range_cnt > MAX_RANGES_DEF) ? MAX_RANGES_DEF : range_cnt;
         found = 0;
         ovf = 0;
         p = 0;
         n = 0;
         case (op_type'(q.op))
            OP_LOAD_PRESET: begin
               if (q.entry_index < MAX_PRESETS_DEF)
                  presets[q.entry_index[7:0]] = '{q.is_drum, q.bank_msb, q.bank_lsb,
                                                  q.program_req};
               return;
            end
            OP_LOAD_LAYER: begin
               if (q.entry_index < MAX_LAYERS_DEF)
                  layers[q.entry_index[8:0]] = '{q.owner_index, q.key_low, q.key_high,
                                                 q.vel_low, q.vel_high, q.instrument_index};
               return;
            end
            OP_LOAD_RANGE: begin
               if (q.entry_index < MAX_RANGES_DEF)
                  ranges[q.entry_index] = '{q.owner_index, q.key_low, q.key_high,
                                            q.vel_low, q.vel_high};
               return;
            end
            default: ;
         endcase
         // each tier rescans from entry 0
         for (int t = TIER_EXACT; t <= TIER_DRUM && !found; t++) begin
            tier = tier_type'(t);
            for (int i = 0; i < np && !found; i++) begin
               if (presets[i].drum == q.is_drum &&
                   (tier == TIER_DRUM || presets[i].prog == q.program_req) &&
                   (tier != TIER_EXACT || (presets[i].msb == q.bank_msb &&
                                           presets[i].lsb == q.bank_lsb))) begin
                  found = 1;
                  p = i;
               end
            end
         end
         if (!found) begin
            push_zone(1'b0, 8'd0, 1'b0, 10'd0, 1'b0, 1'b1);
            return;
         end
         for (int i = 0; i < nl; i++) begin
            if (layers[i].owner != p[7:0]) continue;
            if (!(layers[i].klo <= q.key_low && q.key_low <= layers[i].khi &&
                  layers[i].vlo <= q.vel_low && q.vel_low <= layers[i].vhi)) continue;
            for (int j = 0; j < nr; j++) begin
               if (ranges[j].owner != layers[i].inst) continue;
               if (!(ranges[j].klo <= q.key_low && q.key_low <= ranges[j].khi &&
                     ranges[j].vlo <= q.vel_low && q.vel_low <= ranges[j].vhi)) continue;
               if (n < MAX_MATCHES_DEF) begin
                  push_zone(1'b1, p[7:0], 1'b1, j[9:0], 1'b0, 1'b0);
                  n++;
               end else begin
                  ovf = 1;
               end
            end
         end
         if (n == 0) begin
            push_zone(1'b1, p[7:0], 1'b0, 10'd0, 1'b0, 1'b1);
         end else begin
            r = zone_results.pop_back();
            r.overflow = ovf;
            r.last = 1'b1;
            zone_results = {zone_results, r};
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (zone_results.size() == 0) begin
            $error("unexpected result transaction %h", a);
            errors++;
            return;
         end
         e = zone_results.pop_front();
         if (a.preset_found !== e.preset_found) begin
            $error("preset_found exp %0d got %0d", e.preset_found, a.preset_found); errors++;
         end
         if (a.preset_index !== e.preset_index) begin
            $error("preset_index exp %0d got %0d", e.preset_index, a.preset_index); errors++;
         end
         if (a.zone_valid !== e.zone_valid) begin
            $error("zone_valid exp %0d got %0d", e.zone_valid, a.zone_valid); errors++;
         end
         if (a.range_index !== e.range_index) begin
            $error("range_index exp %0d got %0d", e.range_index, a.range_index); errors++;
         end
         if (a.overflow !== e.overflow) begin
            $error("overflow exp %0d got %0d", e.overflow, a.overflow); errors++;
         end
         if (a.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, a.last); errors++;
         end
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          start = 0;
   logic          busy;
   req_type       req_data = '0;
   logic          rsp_valid;
   rsp_type       rsp_data;
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [10:0]   csr_wdata = '0;

   zone_scoreboard sb = new();
   int burst_left = 0;

   instrument_zone_selector dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   initial begin
      #50ms;
      $display("** instrument_zone_selector: FAILED **");
      $finish;
   end

   // Transaction accepted at the edge where start is high and busy low.
   task automatic send_item(req_type q);
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(q);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 10);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.zone_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; set_counts drops it.
   task automatic write_count(csr_index_type idx, logic [10:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_count(idx, val);
   endtask

   task automatic set_counts(int np, int nl, int nr);
      drain();
      write_count(CSR_PRESET_COUNT, 11'(np));
      write_count(CSR_LAYER_COUNT, 11'(nl));
      write_count(CSR_RANGE_COUNT, 11'(nr));
      csr_valid <= 1'b0;
   endtask

   // Mostly wide windows so that lookups hit; sometimes fully random (may invert).
   function automatic void rand_window(output logic [6:0] lo, output logic [6:0] hi);
      if ($urandom_range(0, 5) == 0) begin
         lo = 7'($urandom);
         hi = 7'($urandom);
      end else begin
         lo = 7'($urandom_range(0, 50));
         hi = 7'($urandom_range(70, 127));
      end
   endfunction

   function automatic req_type rand_load(op_type op, int idx_max, int own_max, int inst_max);
      req_type q;
      q = req_type'(78'({$urandom, $urandom, $urandom}));
      q.op = op;
      q.entry_index = 10'($urandom_range(0, idx_max));
      if (op == OP_LOAD_LAYER) begin
         q.owner_index = 8'($urandom_range(0, own_max));
         q.instrument_index = 8'($urandom_range(0, inst_max));
      end else if (op == OP_LOAD_RANGE) begin
         q.owner_index = 8'($urandom_range(0, inst_max));
      end
      rand_window(q.key_low, q.key_high);
      rand_window(q.vel_low, q.vel_high);
      return q;
   endfunction

   // Fills entries 0..n-1 of each table so no unwritten entry is ever scanned.
   task automatic fill_tables(int np, int nl, int nr, int own_max, int inst_max);
      req_type q;
      for (int i = 0; i < np; i++) begin
         q = rand_load(OP_LOAD_PRESET, 0, own_max, inst_max);
         q.entry_index = 10'(i);
         q.bank_msb = 7'($urandom_range(0, 3));
         q.program_req = 7'($urandom_range(0, 7));
         send_item(q);
      end
      for (int i = 0; i < nl; i++) begin
         q = rand_load(OP_LOAD_LAYER, 0, own_max, inst_max);
         q.entry_index = 10'(i);
         send_item(q);
      end
      for (int i = 0; i < nr; i++) begin
         q = rand_load(OP_LOAD_RANGE, 0, own_max, inst_max);
         q.entry_index = 10'(i);
         send_item(q);
      end
   endtask

   // Lookup mostly aimed at a loaded preset, sometimes perturbed toward a lower tier.
   function automatic req_type rand_lookup(int np);
      req_type q;
      preset_ent_type e;
      q = req_type'(78'({$urandom, $urandom, $urandom}));
      q.op = OP_LOOKUP;
      if (np > 0 && $urandom_range(0, 4) != 0) begin
         e = sb.presets[$urandom_range(0, np - 1)];
         q.is_drum = e.drum;
         q.bank_msb = e.msb;
         q.bank_lsb = e.lsb;
         q.program_req = e.prog;
         case ($urandom_range(0, 3))
            0: q.bank_lsb = 7'($urandom);
            1: q.program_req = 7'($urandom);
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) != 0) begin
         q.key_low = 7'($urandom_range(50, 70));
         q.vel_low = 7'($urandom_range(50, 70));
      end
      return q;
   endfunction

   task automatic random_phase(int items, int np, int nl, int nr, int own_max, int inst_max);
      int k;
      k = 0;
      while (k < items) begin
         case ($urandom_range(0, 9))
            0: send_item(rand_load(OP_LOAD_PRESET, 1023, own_max, inst_max));
            1: send_item(rand_load(OP_LOAD_LAYER, 1023, own_max, inst_max));
            2: send_item(rand_load(OP_LOAD_RANGE, 1023, own_max, inst_max));
            default: begin
               send_item(rand_lookup(np));
               k++;
            end
         endcase
      end
   endtask

   initial begin
      req_type q;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty tables: preset not found; loads past the preset and layer table depths are ignored
      q = '0;
      q.op = OP_LOOKUP;
      send_item(q);
      q = req_type'('1);
      q.op = OP_LOAD_PRESET;
      send_item(q);
      q.op = OP_LOAD_LAYER;
      send_item(q);
      q.op = OP_LOAD_RANGE;
      q.entry_index = 10'd1023;
      send_item(q);
      q = req_type'('1);
      q.op = OP_LOOKUP;
      send_item(q);

      // small tables, all melodic presets
      fill_tables(6, 12, 24, 5, 7);
      for (int i = 0; i < 6; i++) begin
         q = rand_load(OP_LOAD_PRESET, 0, 5, 7);
         q.entry_index = 10'(i);
         q.is_drum = 1'b0;
         q.bank_msb = 7'(i);
         q.program_req = 7'(i % 3);
         send_item(q);
      end
      set_counts(6, 12, 24);
      q = rand_lookup(6);
      q.is_drum = 1'b0; q.bank_msb = 7'd4; q.bank_lsb = sb.presets[4].lsb;
      q.program_req = 7'd1;
      send_item(q);                       // exact match
      q.bank_msb = 7'd100;
      send_item(q);                       // program tier
      q.program_req = 7'd99;
      send_item(q);                       // drum-only tier
      q.is_drum = 1'b1;
      send_item(q);                       // no drum preset: not found
      random_phase(30, 6, 12, 24, 5, 7);

      // cap: five full-window layers over 17 ranges (one inverted), extreme fields
      drain();
      q = req_type'('1);
      q.op = OP_LOAD_PRESET;
      q.entry_index = 10'd0;
      send_item(q);
      for (int i = 0; i < 5; i++) begin
         q = '0;
         q.op = OP_LOAD_LAYER;
         q.entry_index = 10'(i);
         q.instrument_index = 8'd255;
         q.key_high = 7'd127;
         q.vel_high = 7'd127;
         send_item(q);
      end
      for (int i = 0; i < 17; i++) begin
         q = '0;
         q.op = OP_LOAD_RANGE;
         q.entry_index = 10'(i);
         q.owner_index = 8'd255;
         q.key_high = 7'd127;
         q.vel_high = 7'd127;
         if (i == 3) begin                // inverted window
            q.key_low = 7'd90;
            q.key_high = 7'd20;
         end
         send_item(q);
      end
      set_counts(1, 5, 17);               // 80 matches, 16 dropped
      q = req_type'('1);
      q.op = OP_LOOKUP;
      send_item(q);
      q.key_low = 7'd0; q.vel_low = 7'd0;
      send_item(q);
      set_counts(1, 3, 17);               // under the cap
      send_item(q);
      set_counts(1, 4, 17);               // 64 matches, no drop
      send_item(q);

      // medium tables, mixed drum flags
      drain();
      fill_tables(8, 12, 24, 7, 9);
      set_counts(8, 12, 24);
      random_phase(20, 8, 12, 24, 7, 9);

      set_counts(0, 0, 0);
      q = req_type'('1);
      q.op = OP_LOOKUP;
      send_item(q);

      drain();
      repeat (20) @(posedge clock);
      if (sb.zone_results.size() != 0) begin
         $error("%0d expected results never arrived", sb.zone_results.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("** instrument_zone_selector: PASSED **");
      end else begin
         $display("** instrument_zone_selector: FAILED **");
      end
      $finish;
   end
endmodule

`default_nettype wire

/* sim.f */
hdl/izs_pkg.sv
hdl/izs_ctrl.sv
hdl/izs_datapath.sv
hdl/instrument_zone_selector.sv
sim/tb_instrument_zone_selector.sv
